[rtl/tmap_pkg.sv]
`timescale 1ns / 1ps

package tmap_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   localparam int TICK_W  = 31;
   localparam int TEMPO_W = 24;
   localparam int TPQ_W   = 15;
   localparam int MS_W    = 32;
   localparam int PROD_W  = TICK_W + TEMPO_W;
   localparam int DIV_W   = 25;
   localparam int STEP_W  = $clog2(PROD_W);

   localparam logic [TEMPO_W-1:0] DEFAULT_TEMPO = TEMPO_W'(500000);
   localparam logic [9:0]         MS_PER_S      = 10'd1000;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_SPARE  = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_ANSWERED  = 3'd0,
      ST_STORED    = 3'd1,
      ST_CLEARED   = 3'd2,
      ST_FULL      = 3'd3,
      ST_OUT_ORDER = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_MUL,
      S_DIV,
      S_ACC
   } state_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [TICK_W-1:0]  ticks;
      logic [TEMPO_W-1:0] tempo_us_per_quarter;
   } req_type;

   typedef struct packed {
      logic [MS_W-1:0] time_ms;
      logic [2:0]      status;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0]  tick;
      logic [TEMPO_W-1:0] tempo;
   } entry_type;

endpackage

[rtl/tempo_map_ticks_to_ms.sv]
`timescale 1ns / 1ps
// Tempo map: converts a tick position to milliseconds using stored tempo changes.
// Requests arrive on req_valid/req_ready with req_data carrying a command, a tick
// position and a tempo. Every request beat yields exactly one response beat on
// rsp_valid/rsp_ready, in order, carrying time_ms and a status code.
// Clear and append results pass through the staging register to the output. A query
// walks the table through its single-port memory and runs one segment for each change
// at or before the tick plus a final one; each segment steps through S_READ, S_CHECK
// (when a change is read), S_MUL, the 55-step bit-serial divider in S_DIV and S_ACC.
// One request is in flight at a time.
// ticks_per_quarter is written through csr_we/csr_wdata and resets to 96.
// A synchronous reset empties the table and drops any beat not yet delivered.
// No clearing pass is needed, since only entries below the fill count are read.
// When the receiver stalls, the response is held in the output register and the
// following result waits in one staging register; a new request is accepted
// only when that staging register is free, so no beat is lost.
module tempo_map_ticks_to_ms (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  tmap_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output tmap_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [tmap_pkg::TPQ_W-1:0]           csr_wdata
);

   tmap_pkg::entry_type mem [tmap_pkg::TABLE_DEPTH];
   tmap_pkg::entry_type rd_ff;

   tmap_pkg::state_type state_ff, state_in;
   logic [tmap_pkg::TPQ_W-1:0]    tpq_ff;
   logic [tmap_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [tmap_pkg::TICK_W-1:0]   last_tick_ff, last_tick_in;
   logic [tmap_pkg::COUNT_W-1:0]  idx_ff, idx_in;
   logic [tmap_pkg::TICK_W-1:0]   qtick_ff, qtick_in;
   logic [tmap_pkg::TICK_W-1:0]   pos_ff, pos_in;
   logic [tmap_pkg::TEMPO_W-1:0]  tempo_ff, tempo_in;
   logic [tmap_pkg::TICK_W-1:0]   span_ff, span_in;
   logic                          final_ff, final_in;
   logic [tmap_pkg::DIV_W-1:0]    div_ff, div_in;
   logic [tmap_pkg::PROD_W-1:0]   dvd_ff, dvd_in;
   logic [tmap_pkg::DIV_W-1:0]    rem_ff, rem_in;
   logic [tmap_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [tmap_pkg::MS_W-1:0]     acc_ff, acc_in;
   logic                          sat_ff, sat_in;
   logic                          pend_ff, pend_in;
   tmap_pkg::rsp_type             pend_data_ff, pend_data_in;
   logic                          rsp_valid_ff;
   tmap_pkg::rsp_type             rsp_data_ff;

   logic                          wr_en;
   logic                          rd_en;
   logic [tmap_pkg::TPQ_W-1:0]    tpq_eff;
   logic [tmap_pkg::DIV_W:0]      trial;
   logic [tmap_pkg::MS_W:0]       sum;
   logic                          req_fire;
   logic                          move_out;

   assign req_ready = (state_ff == tmap_pkg::S_IDLE) && !pend_ff;
   assign req_fire  = req_valid && req_ready;
   assign move_out  = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign tpq_eff = (tpq_ff == '0) ? tmap_pkg::TPQ_W'(1) : tpq_ff;
   assign trial   = {rem_ff, dvd_ff[tmap_pkg::PROD_W-1]};
   assign sum     = {1'b0, acc_ff} + {1'b0, dvd_ff[tmap_pkg::MS_W-1:0]};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      last_tick_in = last_tick_ff;
      idx_in       = idx_ff;
      qtick_in     = qtick_ff;
      pos_in       = pos_ff;
      tempo_in     = tempo_ff;
      span_in      = span_ff;
      final_in     = final_ff;
      div_in       = div_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      pend_in      = pend_ff && !move_out;
      pend_data_in = pend_data_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      unique case (state_ff)
         tmap_pkg::S_IDLE: begin
            if (req_fire) begin
               pend_data_in.time_ms = '0;
               unique case (req_data.command)
                  tmap_pkg::CMD_CLEAR: begin
                     count_in            = '0;
                     pend_data_in.status = tmap_pkg::ST_CLEARED;
                     pend_in             = 1'b1;
                  end
                  tmap_pkg::CMD_APPEND: begin
                     pend_in = 1'b1;
                     if (count_ff == tmap_pkg::COUNT_W'(tmap_pkg::TABLE_DEPTH)) begin
                        pend_data_in.status = tmap_pkg::ST_FULL;
                     end else if (count_ff != '0 && req_data.ticks < last_tick_ff) begin
                        pend_data_in.status = tmap_pkg::ST_OUT_ORDER;
                     end else begin
                        wr_en               = 1'b1;
                        count_in            = count_ff + 1'b1;
                        last_tick_in        = req_data.ticks;
                        pend_data_in.status = tmap_pkg::ST_STORED;
                     end
                  end
                  default: begin
                     qtick_in = req_data.ticks;
                     pos_in   = '0;
                     tempo_in = tmap_pkg::DEFAULT_TEMPO;
                     idx_in   = '0;
                     acc_in   = '0;
                     sat_in   = 1'b0;
                     div_in   = tmap_pkg::DIV_W'(tpq_eff)
                              * tmap_pkg::DIV_W'(tmap_pkg::MS_PER_S);
                     state_in = tmap_pkg::S_READ;
                  end
               endcase
            end
         end
         tmap_pkg::S_READ: begin
            if (idx_ff < count_ff) begin
               rd_en    = 1'b1;
               state_in = tmap_pkg::S_CHECK;
            end else begin
               span_in  = qtick_ff - pos_ff;
               final_in = 1'b1;
               state_in = tmap_pkg::S_MUL;
            end
         end
         tmap_pkg::S_CHECK: begin
            if (rd_ff.tick > qtick_ff) begin
               span_in  = qtick_ff - pos_ff;
               final_in = 1'b1;
            end else begin
               span_in  = rd_ff.tick - pos_ff;
               final_in = 1'b0;
            end
            state_in = tmap_pkg::S_MUL;
         end
         tmap_pkg::S_MUL: begin
            dvd_in   = tmap_pkg::PROD_W'(span_ff) * tmap_pkg::PROD_W'(tempo_ff);
            rem_in   = '0;
            step_in  = '0;
            state_in = tmap_pkg::S_DIV;
         end
         tmap_pkg::S_DIV: begin
            if (trial >= {1'b0, div_ff}) begin
               rem_in = tmap_pkg::DIV_W'(trial - {1'b0, div_ff});
               dvd_in = {dvd_ff[tmap_pkg::PROD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[tmap_pkg::DIV_W-1:0];
               dvd_in = {dvd_ff[tmap_pkg::PROD_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == tmap_pkg::STEP_W'(tmap_pkg::PROD_W - 1)) begin
               state_in = tmap_pkg::S_ACC;
            end
         end
         tmap_pkg::S_ACC: begin
            acc_in = sum[tmap_pkg::MS_W-1:0];
            sat_in = sat_ff || sum[tmap_pkg::MS_W]
                   || (dvd_ff[tmap_pkg::PROD_W-1:tmap_pkg::MS_W] != '0);
            if (final_ff) begin
               pend_in              = 1'b1;
               pend_data_in.status  = tmap_pkg::ST_ANSWERED;
               pend_data_in.time_ms = (sat_in) ? '1 : acc_in;
               state_in             = tmap_pkg::S_IDLE;
            end else begin
               tempo_in = rd_ff.tempo;
               pos_in   = rd_ff.tick;
               idx_in   = idx_ff + 1'b1;
               state_in = tmap_pkg::S_READ;
            end
         end
         default: state_in = tmap_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[tmap_pkg::IDX_W-1:0]] <= {req_data.ticks, req_data.tempo_us_per_quarter};
      end
      if (rd_en) begin
         rd_ff <= mem[idx_ff[tmap_pkg::IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmap_pkg::S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tpq_ff       <= tmap_pkg::TPQ_W'(96);
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         if (csr_we) begin
            tpq_ff <= csr_wdata;
         end
         if (move_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      last_tick_ff <= last_tick_in;
      idx_ff       <= idx_in;
      qtick_ff     <= qtick_in;
      pos_ff       <= pos_in;
      tempo_ff     <= tempo_in;
      span_ff      <= span_in;
      final_ff     <= final_in;
      div_ff       <= div_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      acc_ff       <= acc_in;
      sat_ff       <= sat_in;
      pend_data_ff <= pend_data_in;
      if (move_out) begin
         rsp_data_ff <= pend_data_ff;
      end
   end

endmodule

[rtl/tmap_checker.sv]
`timescale 1ns / 1ps

module tmap_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input tmap_pkg::rsp_type           rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Response beat changed while stalled.");

   a_zero_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != tmap_pkg::ST_ANSWERED |-> rsp_data.time_ms == '0)
      else $error("Non-query beat carries a nonzero time.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= tmap_pkg::ST_OUT_ORDER)
      else $error("Response beat carries an unused status code.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid after reset.");

endmodule

bind tempo_map_ticks_to_ms tmap_checker u_tmap_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[verif/tempo_map_ticks_to_ms_tb.sv]
`timescale 1ns / 1ps

module tempo_map_ticks_to_ms_tb;

   localparam longint unsigned CYCLE_LIMIT = 20000000;
   localparam int RANDOM_ITEMS = 300;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   tmap_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   tmap_pkg::rsp_type rsp_data;
   logic csr_we;
   logic [tmap_pkg::TPQ_W-1:0] csr_wdata;

   logic [tmap_pkg::TICK_W-1:0] change_tick_tab [tmap_pkg::TABLE_DEPTH];
   logic [tmap_pkg::TEMPO_W-1:0] change_tempo_tab [tmap_pkg::TABLE_DEPTH];
   int unsigned change_fill;
   logic [tmap_pkg::TPQ_W-1:0] tpq_shadow;

   tmap_pkg::rsp_type expected_rsp_q[$];
   int unsigned beats_sent;
   int unsigned rsp_stall_left;
   bit steady;
   bit failed;
   longint unsigned cycle_count;

   tempo_map_ticks_to_ms u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [tmap_pkg::MS_W-1:0] ticks_to_ms(logic [tmap_pkg::TICK_W-1:0] t);
      longint unsigned divisor;
      longint unsigned total;
      logic [tmap_pkg::TEMPO_W-1:0] tempo;
      logic [tmap_pkg::TICK_W-1:0] last;
      divisor = (tpq_shadow == 0) ? 64'd1000 : 64'(tpq_shadow) * 64'd1000;
      total = 0;
      tempo = tmap_pkg::DEFAULT_TEMPO;
      last = '0;
      for (int i = 0; i < change_fill; i++) begin
         if (change_tick_tab[i] > t) break;
         total += (64'(change_tick_tab[i] - last) * 64'(tempo)) / divisor;
         tempo = change_tempo_tab[i];
         last = change_tick_tab[i];
      end
      total += (64'(t - last) * 64'(tempo)) / divisor;
      return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
   endfunction

   function automatic tmap_pkg::rsp_type tempo_map_step(tmap_pkg::req_type r);
      tmap_pkg::rsp_type o;
      o = '0;
      case (tmap_pkg::command_type'(r.command))
         tmap_pkg::CMD_CLEAR: begin
            change_fill = 0;
            o.status = tmap_pkg::ST_CLEARED;
         end
         tmap_pkg::CMD_APPEND: begin
            if (change_fill >= tmap_pkg::TABLE_DEPTH) begin
               o.status = tmap_pkg::ST_FULL;
            end else if (change_fill > 0 && r.ticks < change_tick_tab[change_fill-1]) begin
               o.status = tmap_pkg::ST_OUT_ORDER;
            end else begin
               change_tick_tab[change_fill] = r.ticks;
               change_tempo_tab[change_fill] = r.tempo_us_per_quarter;
               change_fill++;
               o.status = tmap_pkg::ST_STORED;
            end
         end
         default: begin
            o.time_ms = ticks_to_ms(r.ticks);
            o.status = tmap_pkg::ST_ANSWERED;
         end
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      tmap_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_stall_left = steady ? 0 : $urandom_range(0, 13);
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected response beat: time_ms %0d status %0d",
                   rsp_data.time_ms, rsp_data.status);
            failed = 1'b1;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp_data.time_ms !== exp_rsp.time_ms) begin
               $error("time_ms expected %0d actual %0d", exp_rsp.time_ms, rsp_data.time_ms);
               failed = 1'b1;
            end
            if (rsp_data.status !== exp_rsp.status) begin
               $error("status expected %0d actual %0d", exp_rsp.status, rsp_data.status);
               failed = 1'b1;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready = 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_ready = 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   task automatic send_beat(tmap_pkg::command_type cmd, logic [tmap_pkg::TICK_W-1:0] t,
                            logic [tmap_pkg::TEMPO_W-1:0] tp);
      int unsigned gap;
      tmap_pkg::req_type r;
      gap = steady ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      r.command = cmd;
      r.ticks = t;
      r.tempo_us_per_quarter = tp;
      req_data = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_rsp_q.push_back(tempo_map_step(r));
      beats_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_tpq(logic [tmap_pkg::TPQ_W-1:0] v);
      drain();
      csr_we = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      tpq_shadow = v;
   endtask

   task automatic test_directed;
      send_beat(tmap_pkg::CMD_QUERY, '0, '0);
      send_beat(tmap_pkg::CMD_QUERY, 31'h7FFF_FFFF, '0);
      send_beat(tmap_pkg::CMD_SPARE, 31'd960, 24'hFFFFFF);
      send_beat(tmap_pkg::CMD_APPEND, '0, '0);
      send_beat(tmap_pkg::CMD_APPEND, '0, 24'hFFFFFF);
      send_beat(tmap_pkg::CMD_APPEND, 31'd500, 24'd250000);
      send_beat(tmap_pkg::CMD_APPEND, 31'd499, 24'd1);
      send_beat(tmap_pkg::CMD_APPEND, 31'd500, 24'd0);
      send_beat(tmap_pkg::CMD_QUERY, 31'd400, '0);
      send_beat(tmap_pkg::CMD_QUERY, 31'd1000, '0);
      send_beat(tmap_pkg::CMD_SPARE, 31'h7FFF_FFFF, '0);
      write_tpq(15'd1);
      send_beat(tmap_pkg::CMD_APPEND, 31'd2000, 24'hFFFFFF);
      send_beat(tmap_pkg::CMD_QUERY, 31'h7FFF_FFFF, '0);
      write_tpq(15'd0);
      send_beat(tmap_pkg::CMD_QUERY, 31'd2500, '0);
      write_tpq(15'h7FFF);
      send_beat(tmap_pkg::CMD_QUERY, 31'h7FFF_FFFF, 24'h5A5A5A);
      send_beat(tmap_pkg::CMD_CLEAR, 31'h7FFF_FFFF, 24'hFFFFFF);
      send_beat(tmap_pkg::CMD_QUERY, 31'd12345, '0);
      send_beat(tmap_pkg::CMD_APPEND, 31'd5, 24'd1);
      send_beat(tmap_pkg::CMD_QUERY, 31'd7, '0);
      send_beat(tmap_pkg::CMD_CLEAR, '0, '0);
      write_tpq(15'd96);
   endtask

   task automatic test_table_full;
      logic [tmap_pkg::TICK_W-1:0] t;
      t = 31'd10;
      send_beat(tmap_pkg::CMD_CLEAR, '0, '0);
      steady = 1'b1;
      for (int i = 0; i < tmap_pkg::TABLE_DEPTH; i++) begin
         send_beat(tmap_pkg::CMD_APPEND, t, 24'($urandom));
         t = t + (($urandom_range(0, 3) == 0) ? 31'd0 : 31'($urandom_range(1, 5000)));
      end
      steady = 1'b0;
      send_beat(tmap_pkg::CMD_APPEND, t + 31'd1, 24'd1000);
      send_beat(tmap_pkg::CMD_APPEND, '0, 24'd1000);
      send_beat(tmap_pkg::CMD_QUERY, t, '0);
      send_beat(tmap_pkg::CMD_QUERY, t >> 1, '0);
      write_tpq(15'd1);
      send_beat(tmap_pkg::CMD_QUERY, 31'h7FFF_FFFF, '0);
      send_beat(tmap_pkg::CMD_CLEAR, '0, '0);
      write_tpq(15'd96);
   endtask

   task automatic test_random;
      int unsigned start;
      int unsigned n;
      logic [tmap_pkg::TICK_W-1:0] t;
      logic [tmap_pkg::TICK_W-1:0] q;
      start = beats_sent;
      while (beats_sent - start < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 5))
            0: write_tpq(15'($urandom_range(0, 1)));
            1: write_tpq(15'h7FFF);
            2: write_tpq(15'($urandom));
            default: ;
         endcase
         if ($urandom_range(0, 7) == 0) drain();
         if ($urandom_range(0, 5) != 0) begin
            send_beat(tmap_pkg::CMD_CLEAR, 31'($urandom), 24'($urandom));
         end
         t = ($urandom_range(0, 2) == 0) ? 31'($urandom) : 31'($urandom_range(0, 5000));
         n = $urandom_range(0, 12);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_beat(tmap_pkg::CMD_APPEND, 31'($urandom) & t, 24'($urandom));
            end else begin
               send_beat(tmap_pkg::CMD_APPEND, t,
                         ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                     : 24'($urandom_range(100000, 1000000)));
               if ($urandom_range(0, 3) != 0) t = t + 31'($urandom_range(0, 100000));
            end
         end
         n = $urandom_range(1, 5);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
               0: q = 31'($urandom);
               1: q = t;
               default: q = 31'($urandom_range(0, 1) ? t + $urandom_range(0, 9999)
                                                    : $urandom_range(0, t));
            endcase
            send_beat($urandom_range(0, 7) == 0 ? tmap_pkg::CMD_SPARE : tmap_pkg::CMD_QUERY,
                      q, 24'($urandom));
         end
         if ($urandom_range(0, 9) == 0) begin
            send_beat(tmap_pkg::command_type'($urandom_range(0, 3)), 31'($urandom),
                      24'($urandom));
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      rsp_stall_left = 0;
      steady = 1'b0;
      failed = 1'b0;
      beats_sent = 0;
      cycle_count = 0;
      change_fill = 0;
      tpq_shadow = 15'd96;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_table_full();
      test_random();
      drain();
      repeat (100) @(posedge clock);
      if (!failed) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/tmap_pkg.sv
rtl/tempo_map_ticks_to_ms.sv
rtl/tmap_checker.sv
verif/tempo_map_ticks_to_ms_tb.sv
